/* design/obb_overlap_test_2d_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the oriented box overlap test
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef OBB_OVERLAP_TEST_2D_ASSERT_SVH
`define OBB_OVERLAP_TEST_2D_ASSERT_SVH

// same-cycle implication
`define OBBOT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("overlap test assertion failed");

// next-cycle implication
`define OBBOT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("overlap test assertion failed");

`endif

/* design/obbot_pkg.sv */
// ----------------------------------------------------------------------------
// obbot_pkg
// Types and constants shared by the stages of the box overlap test.
// ----------------------------------------------------------------------------
package obbot_pkg;

    localparam int OWN_SHIFT  = 28;
    localparam int DIST_SHIFT = 14;

    typedef struct packed {
        logic signed [19:0] cx;
        logic signed [19:0] cy;
        logic signed [15:0] c;
        logic signed [15:0] s;
        logic        [15:0] hw;
        logic        [15:0] hh;
    } box_t;

    typedef struct packed {
        logic [15:0] hw;
        logic [15:0] hh;
    } ext_t;

    typedef struct packed {
        logic signed [20:0] dx;
        logic signed [20:0] dy;
        logic signed [15:0] ca;
        logic signed [15:0] sa;
        logic signed [15:0] cb;
        logic signed [15:0] sb;
        logic signed [31:0] cc;
        logic signed [31:0] ss;
        logic signed [31:0] sc;
        logic signed [31:0] cs;
        ext_t               ea;
        ext_t               eb;
    } s1_t;

    typedef struct packed {
        logic        [31:0] abs_p;
        logic        [31:0] abs_q;
        logic signed [36:0] dxca;
        logic signed [36:0] dysa;
        logic signed [36:0] dxsa;
        logic signed [36:0] dyca;
        logic signed [36:0] dxcb;
        logic signed [36:0] dysb;
        logic signed [36:0] dxsb;
        logic signed [36:0] dycb;
        ext_t               ea;
        ext_t               eb;
    } s2_t;

    typedef struct packed {
        logic [36:0] lua;
        logic [36:0] lva;
        logic [36:0] lub;
        logic [36:0] lvb;
        logic [47:0] pwb;
        logic [47:0] qhb;
        logic [47:0] qwb;
        logic [47:0] phb;
        logic [47:0] pwa;
        logic [47:0] qha;
        logic [47:0] qwa;
        logic [47:0] pha;
        ext_t        ea;
        ext_t        eb;
    } s3_t;

endpackage

/* design/obbot_prep.sv */
// ----------------------------------------------------------------------------
// obbot_prep
// Stage 1: center difference and the cross products of the two rotations.
// ----------------------------------------------------------------------------
module obbot_prep import obbot_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  box_t a,
    input  box_t b,
    output logic out_valid,
    input  logic out_ready,
    output s1_t  out_word
);

    logic valid_reg;
    s1_t  word_reg;
    s1_t  word_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        word_next.dx = 21'($signed(a.cx)) - 21'($signed(b.cx));
        word_next.dy = 21'($signed(a.cy)) - 21'($signed(b.cy));
        word_next.ca = a.c;
        word_next.sa = a.s;
        word_next.cb = b.c;
        word_next.sb = b.s;
        word_next.cc = 32'($signed(a.c)) * 32'($signed(b.c));
        word_next.ss = 32'($signed(a.s)) * 32'($signed(b.s));
        word_next.sc = 32'($signed(a.s)) * 32'($signed(b.c));
        word_next.cs = 32'($signed(a.c)) * 32'($signed(b.s));
        word_next.ea.hw = a.hw;
        word_next.ea.hh = a.hh;
        word_next.eb.hw = b.hw;
        word_next.eb.hh = b.hh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

/* design/obbot_dot.sv */
// ----------------------------------------------------------------------------
// obbot_dot
// Stage 2: rotation dot and cross magnitudes, center difference products.
// ----------------------------------------------------------------------------
module obbot_dot import obbot_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  s1_t  in_word,
    output logic out_valid,
    input  logic out_ready,
    output s2_t  out_word
);

    logic        valid_reg;
    s2_t         word_reg;
    s2_t         word_next;
    logic signed [32:0] p;
    logic signed [32:0] q;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        p = 33'($signed(in_word.cc)) + 33'($signed(in_word.ss));
        q = 33'($signed(in_word.sc)) - 33'($signed(in_word.cs));
        word_next.abs_p = p[32] ? 32'(-p) : 32'(p);
        word_next.abs_q = q[32] ? 32'(-q) : 32'(q);
        word_next.dxca  = 37'($signed(in_word.dx)) * 37'($signed(in_word.ca));
        word_next.dysa  = 37'($signed(in_word.dy)) * 37'($signed(in_word.sa));
        word_next.dxsa  = 37'($signed(in_word.dx)) * 37'($signed(in_word.sa));
        word_next.dyca  = 37'($signed(in_word.dy)) * 37'($signed(in_word.ca));
        word_next.dxcb  = 37'($signed(in_word.dx)) * 37'($signed(in_word.cb));
        word_next.dysb  = 37'($signed(in_word.dy)) * 37'($signed(in_word.sb));
        word_next.dxsb  = 37'($signed(in_word.dx)) * 37'($signed(in_word.sb));
        word_next.dycb  = 37'($signed(in_word.dy)) * 37'($signed(in_word.cb));
        word_next.ea    = in_word.ea;
        word_next.eb    = in_word.eb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

/* design/obbot_mag.sv */
// ----------------------------------------------------------------------------
// obbot_mag
// Stage 3: distance magnitudes on the four axes and projected extent terms.
// ----------------------------------------------------------------------------
module obbot_mag import obbot_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  s2_t  in_word,
    output logic out_valid,
    input  logic out_ready,
    output s3_t  out_word
);

    logic        valid_reg;
    s3_t         word_reg;
    s3_t         word_next;
    logic signed [37:0] sua;
    logic signed [37:0] sva;
    logic signed [37:0] sub;
    logic signed [37:0] svb;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        sua = 38'($signed(in_word.dxca)) + 38'($signed(in_word.dysa));
        sva = 38'($signed(in_word.dyca)) - 38'($signed(in_word.dxsa));
        sub = 38'($signed(in_word.dxcb)) + 38'($signed(in_word.dysb));
        svb = 38'($signed(in_word.dycb)) - 38'($signed(in_word.dxsb));
        word_next.lua = sua[37] ? 37'(-sua) : 37'(sua);
        word_next.lva = sva[37] ? 37'(-sva) : 37'(sva);
        word_next.lub = sub[37] ? 37'(-sub) : 37'(sub);
        word_next.lvb = svb[37] ? 37'(-svb) : 37'(svb);
        word_next.pwb = 48'(in_word.abs_p) * 48'(in_word.eb.hw);
        word_next.qhb = 48'(in_word.abs_q) * 48'(in_word.eb.hh);
        word_next.qwb = 48'(in_word.abs_q) * 48'(in_word.eb.hw);
        word_next.phb = 48'(in_word.abs_p) * 48'(in_word.eb.hh);
        word_next.pwa = 48'(in_word.abs_p) * 48'(in_word.ea.hw);
        word_next.qha = 48'(in_word.abs_q) * 48'(in_word.ea.hh);
        word_next.qwa = 48'(in_word.abs_q) * 48'(in_word.ea.hw);
        word_next.pha = 48'(in_word.abs_p) * 48'(in_word.ea.hh);
        word_next.ea  = in_word.ea;
        word_next.eb  = in_word.eb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

/* design/obbot_cmp.sv */
// ----------------------------------------------------------------------------
// obbot_cmp
// Stage 4: sum the radii, compare against distance, hold the result word.
// ----------------------------------------------------------------------------
module obbot_cmp import obbot_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  s3_t  in_word,
    output logic out_valid,
    input  logic out_ready,
    output logic overlap
);

    logic        valid_reg;
    logic        overlap_reg;
    logic        overlap_next;
    logic [50:0] l_ua;
    logic [50:0] l_va;
    logic [50:0] l_ub;
    logic [50:0] l_vb;
    logic [50:0] r_ua;
    logic [50:0] r_va;
    logic [50:0] r_ub;
    logic [50:0] r_vb;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign overlap   = overlap_reg;

    always_comb
    begin
        l_ua = 51'(in_word.lua) << DIST_SHIFT;
        l_va = 51'(in_word.lva) << DIST_SHIFT;
        l_ub = 51'(in_word.lub) << DIST_SHIFT;
        l_vb = 51'(in_word.lvb) << DIST_SHIFT;
        r_ua = (51'(in_word.ea.hw) << OWN_SHIFT) + 51'(in_word.pwb) + 51'(in_word.qhb);
        r_va = (51'(in_word.ea.hh) << OWN_SHIFT) + 51'(in_word.qwb) + 51'(in_word.phb);
        r_ub = (51'(in_word.eb.hw) << OWN_SHIFT) + 51'(in_word.pwa) + 51'(in_word.qha);
        r_vb = (51'(in_word.eb.hh) << OWN_SHIFT) + 51'(in_word.qwa) + 51'(in_word.pha);
        overlap_next = !((l_ua > r_ua) || (l_va > r_va) || (l_ub > r_ub) || (l_vb > r_vb));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            overlap_reg <= overlap_next;
        end
    end

endmodule

/* design/obb_overlap_test_2d.sv */
// ----------------------------------------------------------------------------
// obb_overlap_test_2d
// Inputs pass the prep, dot, mag and cmp registers to out_valid. Throughput:
// one box pair per clock unless stalled, set by the four-stage multiply
// pipeline. Each stage holds its word while the next is full; in_ready is
// high whenever out_ready is. Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module obb_overlap_test_2d import obbot_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [19:0] a_center_x,
    input  logic signed [19:0] a_center_y,
    input  logic signed [15:0] a_cos,
    input  logic signed [15:0] a_sin,
    input  logic        [15:0] a_half_width,
    input  logic        [15:0] a_half_height,
    input  logic signed [19:0] b_center_x,
    input  logic signed [19:0] b_center_y,
    input  logic signed [15:0] b_cos,
    input  logic signed [15:0] b_sin,
    input  logic        [15:0] b_half_width,
    input  logic        [15:0] b_half_height,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               overlap
);

    box_t box_a;
    box_t box_b;
    s1_t  s1_word;
    s2_t  s2_word;
    s3_t  s3_word;
    logic s1_valid;
    logic s1_ready;
    logic s2_valid;
    logic s2_ready;
    logic s3_valid;
    logic s3_ready;

    always_comb
    begin
        box_a.cx = a_center_x;
        box_a.cy = a_center_y;
        box_a.c  = a_cos;
        box_a.s  = a_sin;
        box_a.hw = a_half_width;
        box_a.hh = a_half_height;
        box_b.cx = b_center_x;
        box_b.cy = b_center_y;
        box_b.c  = b_cos;
        box_b.s  = b_sin;
        box_b.hw = b_half_width;
        box_b.hh = b_half_height;
    end

    obbot_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a         (box_a),
        .b         (box_b),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_word  (s1_word)
    );

    obbot_dot u_dot
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_word   (s1_word),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_word  (s2_word)
    );

    obbot_mag u_mag
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_word   (s2_word),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_word  (s3_word)
    );

    obbot_cmp u_cmp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid),
        .in_ready  (s3_ready),
        .in_word   (s3_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .overlap   (overlap)
    );

endmodule

/* design/obbot_check.sv */
// ----------------------------------------------------------------------------
// obbot_check
// Port-level checks on the overlap test, bound to the top level.
// ----------------------------------------------------------------------------
`include "obb_overlap_test_2d_assert.svh"

module obbot_check
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic overlap
);

    `OBBOT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(overlap))
    `OBBOT_ASSERT_NOW(a_ready_flow, out_ready, in_ready)
    `OBBOT_ASSERT_NEXT(a_latency, (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready, out_valid)

endmodule

bind obb_overlap_test_2d obbot_check u_check (.*);
